// ===== design/lif_pkg.sv =====
// ----------------------------------------------------------------------------
// lif_pkg: shared definitions for the leaky integrate-and-fire neuron
// Register indexes, field widths and register reset values.
// ----------------------------------------------------------------------------
package lif_pkg;

   localparam int unsigned PotWidth  = 16;
   localparam int unsigned TickWidth = 32;
   localparam int unsigned CsrIdxW   = 3;
   localparam int unsigned CsrDataW  = 16;

   // configuration register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_THRESHOLD        = 3'd0,
      CSR_RESET_POTENTIAL  = 3'd1,
      CSR_REFRACTORY_TICKS = 3'd2,
      CSR_DECAY            = 3'd3,
      CSR_GAIN             = 3'd4
   } csr_index_type;

   // register reset values
   localparam logic signed [PotWidth-1:0] ThresholdRst    = 16'sd5120;
   localparam logic signed [PotWidth-1:0] ResetPotRst     = 16'sd2560;
   localparam logic        [15:0]         RefractoryRst   = 16'd20;
   localparam logic        [15:0]         DecayRst        = 16'd65209;
   localparam logic        [15:0]         GainRst         = 16'd409;

   localparam logic [15:0] SinceMax = 16'hFFFF;

endpackage

// ===== design/lif_neuron_tick.sv =====
// ----------------------------------------------------------------------------
// lif_neuron_tick: leaky integrate-and-fire neuron, one tick per request
// Refractory/threshold check, potential report and Q8.8 leak update with
// saturation; one response per request.
// ----------------------------------------------------------------------------
// Response: registered, valid in the cycle after the request is accepted.
// Throughput: 1 request per cycle while the response side does not stall; the
//   membrane check and leak update are combinational between the neuron state
//   registers, and the response register decouples the output side.
// Reset (synchronous, active high): state cleared, registers to defaults,
//   response register empty.
module lif_neuron_tick
   import lif_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // configuration
   input  logic                        csr_wr_en,
   input  logic [CsrIdxW-1:0]          csr_index,
   input  logic [CsrDataW-1:0]         csr_wdata,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [PotWidth-1:0]  req_input_current,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [PotWidth-1:0]  rsp_potential,
   output logic                        rsp_spike,
   output logic                        rsp_refractory,
   output logic [TickWidth-1:0]        rsp_tick_index
);

   // configuration registers
   logic signed [PotWidth-1:0] threshold_ff;
   logic signed [PotWidth-1:0] reset_pot_ff;
   logic [15:0]                refr_ticks_ff;
   logic [15:0]                decay_ff;
   logic [15:0]                gain_ff;

   // neuron state
   logic signed [PotWidth-1:0] membrane_ff, membrane_in;
   logic                       refr_ff, refr_in;
   logic [15:0]                since_ff, since_in;
   logic [TickWidth-1:0]       tick_ff, tick_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [PotWidth-1:0] rsp_pot_ff;
   logic                       rsp_spike_ff;
   logic                       rsp_refr_ff;
   logic [TickWidth-1:0]       rsp_tick_ff;

   logic                       req_accept;
   logic                       rsp_take;

   // check results
   logic signed [PotWidth-1:0] chk_pot;
   logic                       chk_refr;
   logic                       chk_fire;
   logic [15:0]                chk_since;
   logic [15:0]                since_inc;

   // leak update
   logic signed [32:0]         prod_v;
   logic signed [32:0]         prod_i;
   logic signed [37:0]         leak_sum;
   logic signed [37:0]         leak_rnd;
   logic signed [21:0]         leak_q88;
   logic signed [PotWidth-1:0] leak_sat;

   // handshake: stall only while a response waits and is not taken
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= ThresholdRst;
         reset_pot_ff  <= ResetPotRst;
         refr_ticks_ff <= RefractoryRst;
         decay_ff      <= DecayRst;
         gain_ff       <= GainRst;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_THRESHOLD:        threshold_ff  <= $signed(csr_wdata);
            CSR_RESET_POTENTIAL:  reset_pot_ff  <= $signed(csr_wdata);
            CSR_REFRACTORY_TICKS: refr_ticks_ff <= csr_wdata;
            CSR_DECAY:            decay_ff      <= csr_wdata;
            CSR_GAIN:             gain_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // refractory / threshold check
   assign since_inc = (since_ff == SinceMax) ? since_ff : since_ff + 16'd1;

   always_comb begin
      chk_pot   = membrane_ff;
      chk_refr  = refr_ff;
      chk_fire  = 1'b0;
      chk_since = since_ff;
      if (refr_ff) begin
         chk_since = since_inc;
         if (since_inc >= refr_ticks_ff) begin
            chk_refr = 1'b0;
            chk_pot  = reset_pot_ff;
         end
      end else if (membrane_ff >= threshold_ff) begin
         chk_fire  = 1'b1;
         chk_refr  = 1'b1;
         chk_since = 16'd0;
         chk_pot   = '0;
      end
   end

   // leak update: V*decay (Q.24) + I*gain*16 (Q.24), round half up, saturate
   assign prod_v   = $signed({{17{chk_pot[15]}}, chk_pot}) * $signed({17'd0, decay_ff});
   assign prod_i   = $signed({{17{req_input_current[15]}}, req_input_current})
                   * $signed({17'd0, gain_ff});
   assign leak_sum = {{5{prod_v[32]}}, prod_v} + {{1{prod_i[32]}}, prod_i, 4'b0000};
   assign leak_rnd = leak_sum + 38'sd32768;
   assign leak_q88 = leak_rnd[37:16];

   always_comb begin
      if (leak_q88 > 22'sd32767) begin
         leak_sat = 16'sh7FFF;
      end else if (leak_q88 < -22'sd32768) begin
         leak_sat = 16'sh8000;
      end else begin
         leak_sat = leak_q88[15:0];
      end
   end

   // next state
   always_comb begin
      membrane_in = membrane_ff;
      refr_in     = refr_ff;
      since_in    = since_ff;
      tick_in     = tick_ff;
      if (req_accept) begin
         membrane_in = leak_sat;
         refr_in     = chk_refr;
         since_in    = chk_since;
         tick_in     = tick_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         membrane_ff <= '0;
         refr_ff     <= 1'b0;
         since_ff    <= '0;
         tick_ff     <= '0;
      end else begin
         membrane_ff <= membrane_in;
         refr_ff     <= refr_in;
         since_ff    <= since_in;
         tick_ff     <= tick_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_pot_ff   <= chk_pot;
         rsp_spike_ff <= chk_fire;
         rsp_refr_ff  <= chk_refr;
         rsp_tick_ff  <= tick_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_potential  = rsp_pot_ff;
   assign rsp_spike      = rsp_spike_ff;
   assign rsp_refractory = rsp_refr_ff;
   assign rsp_tick_index = rsp_tick_ff;

   // checks
   a_spike_refr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_spike |-> rsp_refractory && rsp_potential == 16'sd0)
      else $error("spike response without refractory or zero potential");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("request stalled with empty response register");

   a_tick_next: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid && rsp_tick_index == tick_ff - 32'd1)
      else $error("response tick index out of step with tick counter");

   a_fire_enters: assert property (@(posedge clock) disable iff (reset)
      req_accept && chk_fire |=> refr_ff && since_ff == 16'd0)
      else $error("fire did not enter refractory");

endmodule

// ===== dv/lif_neuron_tick_checker.sv =====
// ----------------------------------------------------------------------------
// lif_neuron_tick_checker: response checker for the LIF neuron tick block
// Watches the register, request and response ports, keeps its own copy of the
// neuron state and registers, predicts one response per accepted request and
// compares every accepted response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lif_neuron_tick_checker
   import lif_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [CsrIdxW-1:0]          csr_index,
   input  logic [CsrDataW-1:0]         csr_wdata,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic signed [PotWidth-1:0]  req_input_current,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic signed [PotWidth-1:0]  rsp_potential,
   input  logic                        rsp_spike,
   input  logic                        rsp_refractory,
   input  logic [TickWidth-1:0]        rsp_tick_index,
   output int                          fail_count,
   output int                          pending,
   output int                          ticks_checked,
   output int                          spikes_seen
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [PotWidth-1:0] potential;
      logic                       spike;
      logic                       refractory;
      logic [TickWidth-1:0]       tick_index;
   } tick_result_type;

   // register copies
   logic signed [PotWidth-1:0] fire_level;
   logic signed [PotWidth-1:0] rearm_level;
   logic [15:0]                hold_ticks;
   logic [15:0]                leak_factor;
   logic [15:0]                drive_gain;

   // neuron state copies
   logic signed [PotWidth-1:0] membrane_v;
   logic                       holding;
   logic [15:0]                ticks_since_fire;
   logic [TickWidth-1:0]       tick_counter;

   tick_result_type expected_ticks[$];

   // V*decay + I*gain*16 in Q.24, round half up to Q8.8, saturate
   function automatic logic signed [PotWidth-1:0] leak_step(
      input logic signed [PotWidth-1:0] v,
      input logic signed [PotWidth-1:0] cur
   );
      longint acc;
      longint r;
      acc = longint'(v) * longint'(leak_factor)
          + longint'(cur) * longint'(drive_gain) * 16;
      r = (acc + 32768) >>> 16;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return PotWidth'(r);
   endfunction

   // one tick: refractory/threshold check, report, then leak update
   function automatic tick_result_type predict_tick(input logic signed [PotWidth-1:0] cur);
      tick_result_type res;
      logic            fired;
      fired = 1'b0;
      if (holding) begin
         if (ticks_since_fire != SinceMax) ticks_since_fire = ticks_since_fire + 16'd1;
         if (ticks_since_fire >= hold_ticks) begin
            holding    = 1'b0;
            membrane_v = rearm_level;
         end
      end else if (membrane_v >= fire_level) begin
         fired            = 1'b1;
         holding          = 1'b1;
         ticks_since_fire = '0;
         membrane_v       = '0;
      end
      res.potential  = membrane_v;
      res.spike      = fired;
      res.refractory = holding;
      res.tick_index = tick_counter;
      membrane_v   = leak_step(membrane_v, cur);
      tick_counter = tick_counter + 1;
      return res;
   endfunction

   task automatic check_field(input string name, input longint unsigned tick,
                              input longint want, input longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t ns: tick %0d %s mismatch: expected %0d, actual %0d",
                  $time, tick, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      tick_result_type want;
      if (reset) begin
         fire_level       = ThresholdRst;
         rearm_level      = ResetPotRst;
         hold_ticks       = RefractoryRst;
         leak_factor      = DecayRst;
         drive_gain       = GainRst;
         membrane_v       = '0;
         holding          = 1'b0;
         ticks_since_fire = '0;
         tick_counter     = '0;
         fail_count       = 0;
         ticks_checked    = 0;
         spikes_seen      = 0;
         expected_ticks.delete();
      end else begin
         // register writes; unused indexes fall through
         if (csr_wr_en) begin
            case (csr_index)
               CSR_THRESHOLD:        fire_level  = csr_wdata;
               CSR_RESET_POTENTIAL:  rearm_level = csr_wdata;
               CSR_REFRACTORY_TICKS: hold_ticks  = csr_wdata;
               CSR_DECAY:            leak_factor = csr_wdata;
               CSR_GAIN:             drive_gain  = csr_wdata;
               default: ;
            endcase
         end

         // response side: compare with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            ticks_checked++;
            if (rsp_spike) spikes_seen++;
            if (expected_ticks.size() == 0) begin
               fail_count++;
               $display("%0t ns: unrequested response: expected none, actual tick %0d",
                        $time, rsp_tick_index);
            end else begin
               want = expected_ticks.pop_front();
               check_field("potential", want.tick_index, want.potential, rsp_potential);
               check_field("spike", want.tick_index, want.spike, rsp_spike);
               check_field("refractory", want.tick_index, want.refractory, rsp_refractory);
               check_field("tick_index", want.tick_index, want.tick_index, rsp_tick_index);
            end
         end

         // request side: predict
         if (req_valid && !req_stall)
            expected_ticks.insert(expected_ticks.size(), predict_tick(req_input_current));
      end
      pending = expected_ticks.size();
   end

endmodule

// ===== dv/lif_neuron_tick_tb.sv =====
// ----------------------------------------------------------------------------
// lif_neuron_tick_tb: testbench top for the LIF neuron tick block
// Drives register settings and input current requests through directed and
// random phases with sender gaps and receiver stalls; the checker predicts and
// compares every response, this module gives the verdict.
// ----------------------------------------------------------------------------
module lif_neuron_tick_tb;
   import lif_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumPhases     = 11;
   localparam int PhaseTicks    = 165;
   localparam int IdleLimit     = 2000;

   logic                        clock             = 1'b0;
   logic                        reset             = 1'b1;
   logic                        csr_wr_en         = 1'b0;
   logic [CsrIdxW-1:0]          csr_index         = '0;
   logic [CsrDataW-1:0]         csr_wdata         = '0;
   logic                        req_valid         = 1'b0;
   logic signed [PotWidth-1:0]  req_input_current = '0;
   logic                        rsp_stall         = 1'b0;
   logic                        req_stall;
   logic                        rsp_valid;
   logic signed [PotWidth-1:0]  rsp_potential;
   logic                        rsp_spike;
   logic                        rsp_refractory;
   logic [TickWidth-1:0]        rsp_tick_index;

   int fail_count;
   int pending;
   int ticks_checked;
   int spikes_seen;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int idle_cycles    = 0;

   always #4 clock = ~clock;

   lif_neuron_tick i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_input_current (req_input_current),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_potential     (rsp_potential),
      .rsp_spike         (rsp_spike),
      .rsp_refractory    (rsp_refractory),
      .rsp_tick_index    (rsp_tick_index)
   );

   lif_neuron_tick_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_input_current (req_input_current),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_potential     (rsp_potential),
      .rsp_spike         (rsp_spike),
      .rsp_refractory    (rsp_refractory),
      .rsp_tick_index    (rsp_tick_index),
      .fail_count        (fail_count),
      .pending           (pending),
      .ticks_checked     (ticks_checked),
      .spikes_seen       (spikes_seen)
   );

   // receiver stalls
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // watchdog: cycles with no transfer on any port
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("%0t ns: no transfer for %0d cycles, %0d responses outstanding",
                  $time, IdleLimit, pending);
         $display("** lif_neuron_tick: FAILED **");
         $finish;
      end
   end

   // current mix: mostly positive drive so the neuron fires, plus noise and extremes
   function automatic logic [PotWidth-1:0] pick_current();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return PotWidth'($urandom_range(0, 1536));
      if (sel < 65) return PotWidth'(0 - $urandom_range(0, 1536));
      if (sel < 90) return PotWidth'($urandom);
      case ($urandom_range(0, 3))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   // caller lowers csr_wr_en after the last write of a batch
   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] thr, input logic [15:0] rearm,
                                 input logic [15:0] hold, input logic [15:0] leak,
                                 input logic [15:0] gn);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_RESET_POTENTIAL, rearm);
      write_reg(CSR_REFRACTORY_TICKS, hold);
      write_reg(CSR_DECAY, leak);
      write_reg(CSR_GAIN, gn);
      csr_wr_en <= 1'b0;
   endtask

   // one request; returns at the edge that accepts it
   task automatic send_tick(input logic [PotWidth-1:0] cur);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_input_current <= cur;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int n_ticks);
      for (int i = 0; i < n_ticks; i++) begin
         // sender holds off once per phase until all responses are back
         if (i == n_ticks / 2) wait_drained();
         send_tick(pick_current());
      end
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: saturation both ways at max decay and gain, immediate re-arm
      apply_settings(ThresholdRst, ResetPotRst, 16'd0, 16'hFFFF, 16'hFFFF);
      send_tick(16'h7FFF);
      send_tick(16'h7FFF);
      send_tick(16'h8000);
      send_tick(16'h8000);
      send_tick(16'h0000);
      send_tick(16'hFFFF);
      send_tick(16'h0001);
      wait_drained();

      // directed: lowest threshold fires whenever not refractory, one-tick hold
      apply_settings(16'h8000, 16'h8000, 16'd1, DecayRst, GainRst);
      repeat (6) send_tick(pick_current());
      wait_drained();

      // directed: writes to unused indexes must change nothing
      for (int k = CSR_GAIN + 1; k < 2 ** CsrIdxW; k++) write_reg(CsrIdxW'(k), 16'hFFFF);
      write_reg(CSR_REFRACTORY_TICKS, 16'd2);
      csr_wr_en <= 1'b0;
      repeat (7) send_tick(pick_current());
      wait_drained();

      // random phases, each with its own settings and idle pattern
      for (int p = 0; p < NumPhases; p++) begin
         case (p % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         if (p == 0)
            apply_settings(ThresholdRst, ResetPotRst, RefractoryRst, DecayRst, GainRst);
         else if (p == 1)
            apply_settings(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         else if (p == 2)
            apply_settings(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
         else if (p < 9)
            apply_settings(16'($urandom_range(256, 8192)),
                           16'($urandom_range(0, 8192) - 4096),
                           16'($urandom_range(0, 8)),
                           16'($urandom_range(60000, 65535)),
                           16'($urandom_range(100, 4096)));
         else
            apply_settings(16'($urandom), 16'($urandom), 16'($urandom_range(0, 40)),
                           16'($urandom), 16'($urandom));
         run_phase(PhaseTicks);
      end

      repeat (10) @(posedge clock);
      $display("Run covered %0d ticks over %0d register settings, %0d spikes fired,",
               ticks_checked, NumPhases + 3, spikes_seen);
      $display("with sender gaps, receiver stalls and extreme register values.");
      if (fail_count == 0)
         $display("** lif_neuron_tick: PASSED **");
      else
         $display("** lif_neuron_tick: FAILED **");
      $finish;
   end

endmodule
